// ===== sv/dcd_pkg.sv =====
// Shared types, command codes and byte tables for the drive command decoder.
// No dependencies; imported by every module of the block.
package dcd_pkg;

  // Command characters
  localparam logic [7:0] CMD_SPD_UP   = 8'h31;  // '1'
  localparam logic [7:0] CMD_FWD      = 8'h32;  // '2'
  localparam logic [7:0] CMD_SPD_DN   = 8'h33;  // '3'
  localparam logic [7:0] CMD_STEER_LT = 8'h34;  // '4'
  localparam logic [7:0] CMD_STOP     = 8'h35;  // '5'
  localparam logic [7:0] CMD_STEER_RT = 8'h36;  // '6'
  localparam logic [7:0] CMD_WATCH    = 8'h37;  // '7'
  localparam logic [7:0] CMD_REV      = 8'h38;  // '8'
  localparam logic [7:0] CMD_HOLD     = 8'h39;  // '9'

  // Configuration register indexes
  localparam logic [2:0] REG_SPEED_STEP    = 3'd0;
  localparam logic [2:0] REG_SPEED_CEILING = 3'd1;
  localparam logic [2:0] REG_RUN_FLOOR     = 3'd2;
  localparam logic [2:0] REG_START_SPEED   = 3'd3;
  localparam logic [2:0] REG_WHEEL_FLOOR   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [8:0]  RST_SPEED_STEP    = 9'd200;
  localparam logic [10:0] RST_SPEED_CEILING = 11'd1600;
  localparam logic [10:0] RST_RUN_FLOOR     = 11'd800;
  localparam logic [10:0] RST_START_SPEED   = 11'd1200;
  localparam logic [10:0] RST_WHEEL_FLOOR   = 11'd400;

  // Run lengths in bytes
  localparam int unsigned ECHO_LEN  = 6;
  localparam int unsigned FRAME_LEN = 7;

  // LED frame selection for one command
  typedef enum logic [2:0] {
    FR_NONE      = 3'd0,
    FR_WATCH_ON  = 3'd1,
    FR_WATCH_OFF = 3'd2,
    FR_HOLD_ON   = 3'd3,
    FR_HOLD_OFF  = 3'd4
  } dcd_frame_t;

  // Drive state as reported with every byte of a run
  typedef struct packed {
    logic [10:0]        speed;
    logic signed [11:0] steer;
    logic               fwd;
    logic               rev;
    logic               stopped;
    logic               watch;
    logic               clear;
    logic               hold;
    logic signed [15:0] yaw_goal;
  } dcd_state_t;

  // One queued command: what to send and the state to report
  typedef struct packed {
    logic [7:0] cmd;
    dcd_frame_t frame;
    dcd_state_t st;
  } dcd_entry_t;

  // Echo bytes: 'c' ':' cmd '0' CR LF
  function automatic logic [7:0] echo_byte(input logic [7:0] cmd, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = 8'h63;
      3'd1:    b = 8'h3A;
      3'd2:    b = cmd;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h0D;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  // LED frame bytes: header, length, target, on/off, checksum, trailer
  function automatic logic [7:0] frame_byte(input dcd_frame_t f, input logic [2:0] k);
    logic       is_watch;
    logic       is_on;
    logic [7:0] b;
    is_watch = (f == FR_WATCH_ON) || (f == FR_WATCH_OFF);
    is_on    = (f == FR_WATCH_ON) || (f == FR_HOLD_ON);
    case (k)
      3'd0: b = 8'hA5;
      3'd1: b = 8'h5A;
      3'd2: b = 8'h05;
      3'd3: b = is_watch ? 8'hE7 : 8'hE8;
      3'd4: b = is_on ? 8'h00 : 8'h01;
      3'd5: begin
        case (f)
          FR_WATCH_ON: b = 8'hEC;
          FR_HOLD_OFF: b = 8'hEE;
          default:     b = 8'hED;
        endcase
      end
      default: b = 8'hAA;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/dcd_front.sv =====
// Front end: configuration registers, command decode and drive state update.
// Depends on dcd_pkg; pushes one dcd_entry_t per accepted command.
module dcd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_cmd_byte,
  input  logic signed [15:0]  in_yaw_now,
  input  logic                q_full,
  output logic                q_push,
  output dcd_pkg::dcd_entry_t q_wdata
);
  import dcd_pkg::*;

  logic [8:0]  step_r;
  logic [10:0] ceil_r, rfl_r, start_r, wfl_r;
  dcd_state_t  st_r, st_nxt;
  dcd_frame_t  frame;

  logic signed [14:0] spd_s, step_s, ceil_s, rfl_s, wfl_s, steer_s, t;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= RST_SPEED_STEP;
      ceil_r  <= RST_SPEED_CEILING;
      rfl_r   <= RST_RUN_FLOOR;
      start_r <= RST_START_SPEED;
      wfl_r   <= RST_WHEEL_FLOOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_STEP:    step_r  <= cfg_wdata[8:0];
        REG_SPEED_CEILING: ceil_r  <= cfg_wdata;
        REG_RUN_FLOOR:     rfl_r   <= cfg_wdata;
        REG_START_SPEED:   start_r <= cfg_wdata;
        REG_WHEEL_FLOOR:   wfl_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Widened operands for the compares
  assign spd_s   = signed'({4'b0, st_r.speed});
  assign step_s  = signed'({6'b0, step_r});
  assign ceil_s  = signed'({4'b0, ceil_r});
  assign rfl_s   = signed'({4'b0, rfl_r});
  assign wfl_s   = signed'({4'b0, wfl_r});
  assign steer_s = 15'(st_r.steer);

  // Command decode and next drive state
  always_comb begin
    st_nxt = st_r;
    frame  = FR_NONE;
    t      = '0;
    unique case (in_cmd_byte)
      CMD_WATCH: begin
        st_nxt.watch = ~st_r.watch;
        st_nxt.clear = ~st_r.watch;
        frame        = st_r.watch ? FR_WATCH_OFF : FR_WATCH_ON;
      end
      CMD_HOLD: begin
        st_nxt.hold     = ~st_r.hold;
        st_nxt.yaw_goal = in_yaw_now;
        frame           = st_r.hold ? FR_HOLD_OFF : FR_HOLD_ON;
      end
      CMD_STOP: begin
        st_nxt.stopped = 1'b1;
        st_nxt.steer   = '0;
        st_nxt.speed   = '0;
        st_nxt.fwd     = 1'b0;
        st_nxt.rev     = 1'b0;
      end
      CMD_FWD: begin
        st_nxt.steer = '0;
        st_nxt.speed = '0;
        // forward start only with a clear path
        if (st_r.clear) begin
          st_nxt.fwd      = 1'b1;
          st_nxt.rev      = 1'b0;
          st_nxt.stopped  = 1'b0;
          st_nxt.speed    = start_r;
          st_nxt.yaw_goal = in_yaw_now;
        end
      end
      CMD_REV: begin
        st_nxt.steer   = '0;
        st_nxt.stopped = 1'b1;
        st_nxt.fwd     = 1'b0;
        st_nxt.rev     = 1'b1;
        st_nxt.speed   = start_r;
      end
      CMD_SPD_UP: begin
        st_nxt.steer = '0;
        t = spd_s + step_s;
        if (t > ceil_s) t = spd_s;
        if (t < rfl_s) t = rfl_s;
        st_nxt.speed = t[10:0];
      end
      CMD_SPD_DN: begin
        st_nxt.steer = '0;
        t = spd_s - step_s;
        if (t < rfl_s) begin
          st_nxt.speed   = '0;
          st_nxt.stopped = 1'b1;
        end else begin
          st_nxt.speed = t[10:0];
        end
      end
      CMD_STEER_RT: begin
        t = steer_s + step_s;
        if (!((t + spd_s > ceil_s) || (spd_s - t < wfl_s))) st_nxt.steer = t[11:0];
      end
      CMD_STEER_LT: begin
        t = steer_s - step_s;
        if (!((spd_s - t > ceil_s) || (spd_s + t < wfl_s))) st_nxt.steer = t[11:0];
      end
      default: ;  // echo only
    endcase
  end

  // State register, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (q_push) begin
      st_r <= st_nxt;
    end
  end

  assign q_wdata.cmd   = in_cmd_byte;
  assign q_wdata.frame = frame;
  assign q_wdata.st    = st_nxt;

endmodule

// ===== sv/dcd_queue.sv =====
// Two-entry command queue between decode front and byte serializer.
// Depends on dcd_pkg for the entry type.
module dcd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dcd_pkg::dcd_entry_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                rvalid,
  output dcd_pkg::dcd_entry_t rdata
);
  import dcd_pkg::*;

  dcd_entry_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == 2'd2);
  assign rvalid = (cnt_r != 2'd0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rvalid)
    else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== sv/dcd_back.sv =====
// Back end: serializes echo and LED frame bytes of each queued command
// into a registered output stage. Depends on dcd_pkg.
module dcd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  dcd_pkg::dcd_entry_t    q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output dcd_pkg::dcd_state_t    out_st
);
  import dcd_pkg::*;

  localparam logic [3:0] ECHO_END = 4'(ECHO_LEN - 1);
  localparam logic [3:0] RUN_END  = 4'(ECHO_LEN + FRAME_LEN - 1);

  logic [3:0] idx_r;
  logic [3:0] fidx;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  dcd_state_t st_r;
  logic       load;
  logic       is_last;
  logic [7:0] cur_byte;

  assign load    = q_valid && (!out_valid_r || out_ready);
  assign fidx    = idx_r - 4'(ECHO_LEN);
  assign is_last = ((q_rdata.frame == FR_NONE) && (idx_r == ECHO_END)) || (idx_r == RUN_END);
  assign q_pop   = load && is_last;

  // Byte select: echo first, then frame
  always_comb begin
    if (idx_r < 4'(ECHO_LEN)) cur_byte = echo_byte(q_rdata.cmd, idx_r[2:0]);
    else                      cur_byte = frame_byte(q_rdata.frame, fidx[2:0]);
  end

  // Byte counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 4'd0 : idx_r + 4'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= is_last;
      st_r   <= q_rdata.st;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_st    = st_r;

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r && last_r)
    else $error("entry released without final byte");
  a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == 4'd0)
    else $error("byte counter not rewound after run");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= RUN_END)
    else $error("byte counter past run end");
  a_echo_only_short: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_rdata.frame == FR_NONE) |-> idx_r <= ECHO_END)
    else $error("echo-only run past echo end");

endmodule

// ===== sv/drive_command_decoder.sv =====
// Top level of the drive command decoder: front decode, queue, back serializer.
// Depends on dcd_pkg, dcd_front, dcd_queue and dcd_back.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | cmd_byte, yaw_now
//   out     | output    | out_valid/out_ready| tx_byte, last_byte, drive state
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// A command is decoded and applied in its accept cycle; its run of 6 bytes
// (echo only) or 13 bytes (echo plus LED frame) then leaves the serializer at
// one byte per cycle while out_ready holds.
// The two-entry queue lets new commands enter while a run is still sent.
// Synchronous active-low reset clears state and loads the register defaults.
// An output stall holds the current byte and, once the queue fills, in_ready.
module drive_command_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_cmd_byte,
  input  logic signed [15:0] in_yaw_now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_last_byte,
  output logic [10:0]        out_drive_speed,
  output logic signed [11:0] out_drive_steer,
  output logic               out_forward_on,
  output logic               out_reverse_on,
  output logic               out_stop_mark,
  output logic               out_watch_on,
  output logic               out_clear_on,
  output logic               out_hold_on,
  output logic signed [15:0] out_yaw_target
);
  import dcd_pkg::*;

  logic       q_full, q_push, q_pop, q_valid;
  dcd_entry_t q_wdata, q_rdata;
  dcd_state_t st;

  dcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd_byte(in_cmd_byte),
    .in_yaw_now (in_yaw_now),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  dcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rvalid(q_valid),
    .rdata (q_rdata)
  );

  dcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_tx_byte),
    .out_last (out_last_byte),
    .out_st   (st)
  );

  assign out_drive_speed = st.speed;
  assign out_drive_steer = st.steer;
  assign out_forward_on  = st.fwd;
  assign out_reverse_on  = st.rev;
  assign out_stop_mark   = st.stopped;
  assign out_watch_on    = st.watch;
  assign out_clear_on    = st.clear;
  assign out_hold_on     = st.hold;
  assign out_yaw_target  = st.yaw_goal;

endmodule

// ===== bench/drive_command_decoder_tb.sv =====
// Self-checking testbench for drive_command_decoder: directed and random commands
// checked byte by byte against an in-bench drive state predictor.
// Depends on dcd_pkg and the drive_command_decoder RTL.
module drive_command_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;   // two queued runs of 13 bytes plus margin
  localparam int MAX_REPORTS  = 50;
  localparam int RANDOM_ITEMS = 116;  // per idling phase

  // LED frames, first byte in the top bits
  localparam logic [55:0] LED_WATCH_ON  = 56'hA5_5A_05_E7_00_EC_AA;
  localparam logic [55:0] LED_WATCH_OFF = 56'hA5_5A_05_E7_01_ED_AA;
  localparam logic [55:0] LED_HOLD_ON   = 56'hA5_5A_05_E8_00_ED_AA;
  localparam logic [55:0] LED_HOLD_OFF  = 56'hA5_5A_05_E8_01_EE_AA;

  // One transmitted byte with the drive state reported beside it
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    dcd_state_t st;
  } tx_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_SPEED_STEP;
  logic [10:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_cmd_byte = '0;
  logic signed [15:0] in_yaw_now = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_tx_byte;
  logic               out_last_byte;
  logic [10:0]        out_drive_speed;
  logic signed [11:0] out_drive_steer;
  logic               out_forward_on;
  logic               out_reverse_on;
  logic               out_stop_mark;
  logic               out_watch_on;
  logic               out_clear_on;
  logic               out_hold_on;
  logic signed [15:0] out_yaw_target;

  drive_command_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd_byte     (in_cmd_byte),
    .in_yaw_now      (in_yaw_now),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tx_byte     (out_tx_byte),
    .out_last_byte   (out_last_byte),
    .out_drive_speed (out_drive_speed),
    .out_drive_steer (out_drive_steer),
    .out_forward_on  (out_forward_on),
    .out_reverse_on  (out_reverse_on),
    .out_stop_mark   (out_stop_mark),
    .out_watch_on    (out_watch_on),
    .out_clear_on    (out_clear_on),
    .out_hold_on     (out_hold_on),
    .out_yaw_target  (out_yaw_target)
  );

  // Predicted drive state and register copies
  int          speed_lvl, steer_ofs;
  logic        drv_fwd, drv_rev, front_stop, watch_mode, path_ok, hold_mode;
  logic [15:0] heading_goal;
  int          step_cfg, ceil_cfg, floor_cfg, start_cfg, wheel_cfg;

  tx_result_t  tx_expected[$];
  int          error_count = 0;
  int          rx_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset values of the predictor
  initial begin
    speed_lvl = 0;
    steer_ofs = 0;
    {drv_fwd, drv_rev, front_stop, watch_mode, path_ok, hold_mode} = '0;
    heading_goal = '0;
    step_cfg  = RST_SPEED_STEP;
    ceil_cfg  = RST_SPEED_CEILING;
    floor_cfg = RST_RUN_FLOOR;
    start_cfg = RST_START_SPEED;
    wheel_cfg = RST_WHEEL_FLOOR;
  end

  // Apply one command to the predicted state and queue its byte run
  function automatic void apply_command(input logic [7:0] cmd, input logic [15:0] yaw);
    dcd_frame_t  frame;
    logic [47:0] echo;
    logic [55:0] led;
    dcd_state_t  snap;
    tx_result_t  res;
    int          k;
    frame = FR_NONE;
    led   = '0;
    case (cmd)
      CMD_WATCH: begin
        watch_mode = ~watch_mode;
        frame      = watch_mode ? FR_WATCH_ON : FR_WATCH_OFF;
        path_ok    = watch_mode;
      end
      CMD_HOLD: begin
        hold_mode    = ~hold_mode;
        frame        = hold_mode ? FR_HOLD_ON : FR_HOLD_OFF;
        heading_goal = yaw;
      end
      CMD_STOP: begin
        front_stop = 1'b1;
        steer_ofs  = 0;
        speed_lvl  = 0;
        drv_fwd    = 1'b0;
        drv_rev    = 1'b0;
      end
      CMD_FWD: begin
        // without a clear path only speed and steering are dropped
        steer_ofs = 0;
        speed_lvl = 0;
        if (path_ok) begin
          drv_fwd      = 1'b1;
          drv_rev      = 1'b0;
          front_stop   = 1'b0;
          speed_lvl    = start_cfg;
          heading_goal = yaw;
        end
      end
      CMD_REV: begin
        steer_ofs  = 0;
        front_stop = 1'b1;
        drv_fwd    = 1'b0;
        drv_rev    = 1'b1;
        speed_lvl  = start_cfg;
      end
      CMD_SPD_UP: begin
        steer_ofs = 0;
        speed_lvl += step_cfg;
        if (speed_lvl > ceil_cfg) speed_lvl -= step_cfg;
        if (speed_lvl < floor_cfg) speed_lvl = floor_cfg;
      end
      CMD_SPD_DN: begin
        steer_ofs = 0;
        speed_lvl -= step_cfg;
        if (speed_lvl < floor_cfg) begin
          speed_lvl  = 0;
          front_stop = 1'b1;
        end
      end
      CMD_STEER_RT: begin
        steer_ofs += step_cfg;
        if (steer_ofs + speed_lvl > ceil_cfg || speed_lvl - steer_ofs < wheel_cfg)
          steer_ofs -= step_cfg;
      end
      CMD_STEER_LT: begin
        steer_ofs -= step_cfg;
        if (speed_lvl - steer_ofs > ceil_cfg || speed_lvl + steer_ofs < wheel_cfg)
          steer_ofs += step_cfg;
      end
      default: ;
    endcase

    snap.speed    = speed_lvl[10:0];
    snap.steer    = steer_ofs[11:0];
    snap.fwd      = drv_fwd;
    snap.rev      = drv_rev;
    snap.stopped  = front_stop;
    snap.watch    = watch_mode;
    snap.clear    = path_ok;
    snap.hold     = hold_mode;
    snap.yaw_goal = heading_goal;

    // echo: 'c' ':' cmd '0' CR LF
    echo = {8'h63, 8'h3A, cmd, 8'h30, 8'h0D, 8'h0A};
    for (k = 0; k < ECHO_LEN; k++) begin
      res.tx   = echo[47 - 8*k -: 8];
      res.last = (frame == FR_NONE) && (k == ECHO_LEN - 1);
      res.st   = snap;
      tx_expected.push_back(res);
    end

    case (frame)
      FR_WATCH_ON:  led = LED_WATCH_ON;
      FR_WATCH_OFF: led = LED_WATCH_OFF;
      FR_HOLD_ON:   led = LED_HOLD_ON;
      FR_HOLD_OFF:  led = LED_HOLD_OFF;
      default:      ;
    endcase
    if (frame != FR_NONE) begin
      for (k = 0; k < FRAME_LEN; k++) begin
        res.tx   = led[55 - 8*k -: 8];
        res.last = (k == FRAME_LEN - 1);
        res.st   = snap;
        tx_expected.push_back(res);
      end
    end
  endfunction

  // One line per mismatch, printing capped
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at byte %0d: %s got %0h expected %0h", rx_count, what, got, want);
  endtask

  // Compare one received byte with the oldest expectation
  task automatic check_tx_byte();
    tx_result_t want;
    if (tx_expected.size() == 0) begin
      report_mismatch("byte with nothing pending, tx_byte", out_tx_byte, 0);
    end else begin
      want = tx_expected.pop_front();
      if (out_tx_byte !== want.tx) report_mismatch("tx_byte", out_tx_byte, want.tx);
      if (out_last_byte !== want.last) report_mismatch("last_byte", out_last_byte, want.last);
      if (out_drive_speed !== want.st.speed)
        report_mismatch("drive_speed", out_drive_speed, want.st.speed);
      if (out_drive_steer !== want.st.steer)
        report_mismatch("drive_steer", out_drive_steer[11:0], want.st.steer[11:0]);
      if (out_forward_on !== want.st.fwd)
        report_mismatch("forward_on", out_forward_on, want.st.fwd);
      if (out_reverse_on !== want.st.rev)
        report_mismatch("reverse_on", out_reverse_on, want.st.rev);
      if (out_stop_mark !== want.st.stopped)
        report_mismatch("stop_mark", out_stop_mark, want.st.stopped);
      if (out_watch_on !== want.st.watch) report_mismatch("watch_on", out_watch_on, want.st.watch);
      if (out_clear_on !== want.st.clear) report_mismatch("clear_on", out_clear_on, want.st.clear);
      if (out_hold_on !== want.st.hold) report_mismatch("hold_on", out_hold_on, want.st.hold);
      if (out_yaw_target !== want.st.yaw_goal)
        report_mismatch("yaw_target", out_yaw_target[15:0], want.st.yaw_goal[15:0]);
    end
    rx_count++;
  endtask

  // Predict on each accepted command, check each accepted byte
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) apply_command(in_cmd_byte, in_yaw_now);
    if (rst_n && out_valid && out_ready) check_tx_byte();
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Send one command transaction, with an optional random gap before it
  task automatic send_command(input logic [7:0] cmd, input logic [15:0] yaw);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_cmd_byte <= cmd;
    in_yaw_now  <= yaw;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and let every pending byte drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tx_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle
  task automatic write_register(input logic [2:0] idx, input logic [10:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPEED_STEP:    step_cfg  = value[8:0];
      REG_SPEED_CEILING: ceil_cfg  = value;
      REG_RUN_FLOOR:     floor_cfg = value;
      REG_START_SPEED:   start_cfg = value;
      REG_WHEEL_FLOOR:   wheel_cfg = value;
      default:           ;
    endcase
    @(posedge clk);
  endtask

  // Echo-only bytes and forward start without a clear path
  task automatic test_echo_only();
    send_command(8'h00, 16'h0000);
    send_command(8'hFF, 16'hFFFF);
    send_command(CMD_FWD, 16'h7FFF);
  endtask

  // Watch and hold toggles with their LED frames
  task automatic test_mode_toggles();
    send_command(CMD_WATCH, 16'h8000);
    send_command(CMD_HOLD, 16'h8000);
  endtask

  // Forward start, ceiling undo, drop to stop, floor raise
  task automatic test_speed_rules();
    send_command(CMD_FWD, 16'h7FFF);
    repeat (3) send_command(CMD_SPD_UP, 16'h1234);
    repeat (5) send_command(CMD_SPD_DN, 16'h4321);
    send_command(CMD_SPD_UP, 16'h0000);
  endtask

  // Steering steps at run floor speed, wheel floor undo on the right
  task automatic test_steering_bounds();
    repeat (3) send_command(CMD_STEER_RT, 16'h00FF);
    repeat (4) send_command(CMD_STEER_LT, 16'hFF00);
  endtask

  // Reverse, stop and watch off
  task automatic test_direction_bits();
    send_command(CMD_REV, 16'h5555);
    send_command(CMD_STOP, 16'hAAAA);
    send_command(CMD_WATCH, 16'h0001);
  endtask

  // Register extremes: masked step, full-scale limits, zero step and ceiling under full-scale floors, unknown indexes
  task automatic test_register_extremes();
    wait_idle();
    write_register(REG_SPEED_STEP, 11'h7FF);
    write_register(REG_SPEED_CEILING, 11'd2047);
    write_register(REG_RUN_FLOOR, 11'd0);
    write_register(REG_START_SPEED, 11'd2047);
    write_register(REG_WHEEL_FLOOR, 11'd0);
    write_register(3'd5, 11'h7FF);
    write_register(3'd7, 11'h000);
    send_command(CMD_REV, 16'h0F0F);
    send_command(CMD_SPD_UP, 16'hF0F0);
    send_command(CMD_STEER_RT, 16'h0000);
    send_command(CMD_SPD_DN, 16'h0000);
    send_command(CMD_STEER_RT, 16'h0000);
    wait_idle();
    write_register(REG_SPEED_STEP, 11'd0);
    write_register(REG_SPEED_CEILING, 11'd0);
    write_register(REG_RUN_FLOOR, 11'd2047);
    write_register(REG_START_SPEED, 11'd0);
    write_register(REG_WHEEL_FLOOR, 11'd2047);
    send_command(CMD_SPD_UP, 16'h7FFF);
    send_command(CMD_STEER_LT, 16'h8000);
  endtask

  // Random limits, then a mix of mostly command digits and arbitrary bytes
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int          ceil_v, floor_v;
    logic [7:0]  cmd;
    wait_idle();
    ceil_v  = $urandom_range(900, 2047);
    floor_v = $urandom_range(0, ceil_v);
    write_register(REG_SPEED_STEP, 11'($urandom_range(1, 511)));
    write_register(REG_SPEED_CEILING, 11'(ceil_v));
    write_register(REG_RUN_FLOOR, 11'(floor_v));
    write_register(REG_START_SPEED, 11'($urandom_range(floor_v, ceil_v)));
    write_register(REG_WHEEL_FLOOR, 11'($urandom_range(0, floor_v)));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) cmd = 8'($urandom_range(CMD_SPD_UP, CMD_HOLD));
      else                         cmd = 8'($urandom_range(0, 255));
      send_command(cmd, 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_echo_only();
    test_mode_toggles();
    test_speed_rules();
    test_steering_bounds();
    test_direction_bits();
    test_register_extremes();
    test_random_traffic(12, 67);
    test_random_traffic(67, 12);
    test_random_traffic(0, 0);
    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
